>>> src/bplc_pkg.sv
// Shared types and constants for the button press length classifier.
package bplc_pkg;

    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 8;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ENABLE      = 2'd0,
        REG_DEBOUNCE    = 2'd1,
        REG_SHORT_LIMIT = 2'd2,
        REG_LONG_LIMIT  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_SHORT  = 2'd1,
        CLS_MEDIUM = 2'd2,
        CLS_LONG   = 2'd3
    } press_class_t;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET    = 16'd40;
    localparam logic [CFG_WIDTH-1:0] SHORT_LIMIT_RESET = 16'd500;
    localparam logic [CFG_WIDTH-1:0] LONG_LIMIT_RESET  = 16'd2000;

    typedef struct packed {
        logic         idle_flag;
        press_class_t press_class;
    } result_t;

endpackage

>>> src/bplc_core.sv
// Configuration registers, phase tracking and press classification.
module bplc_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [bplc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [bplc_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    input  logic                                beat,
    input  logic                                level,
    output bplc_pkg::result_t                   result
);

    localparam int CMP_W = (COUNT_WIDTH > bplc_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                               : bplc_pkg::CFG_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2,
        PH_SPARE    = 2'd3
    } phase_t;

    logic                           enable_reg;
    logic [bplc_pkg::CFG_WIDTH-1:0] debounce_ticks_reg;
    logic [bplc_pkg::CFG_WIDTH-1:0] short_limit_reg;
    logic [bplc_pkg::CFG_WIDTH-1:0] long_limit_reg;

    phase_t                         phase_reg, phase_next;
    logic                           prev_level_reg;
    logic [COUNT_WIDTH-1:0]         debounce_count_reg, debounce_count_next;
    logic [COUNT_WIDTH-1:0]         hold_count_reg, hold_count_next;
    logic [COUNT_WIDTH-1:0]         deb_inc, hold_inc;
    bplc_pkg::press_class_t         cls;

    assign deb_inc  = (debounce_count_reg == CNT_MAX) ? CNT_MAX : debounce_count_reg + 1'b1;
    assign hold_inc = (hold_count_reg == CNT_MAX) ? CNT_MAX : hold_count_reg + 1'b1;

    always_comb
    begin
        phase_next          = phase_reg;
        debounce_count_next = debounce_count_reg;
        hold_count_next     = hold_count_reg;
        cls                 = bplc_pkg::CLS_NONE;
        if (!enable_reg)
        begin
            phase_next          = PH_IDLE;
            debounce_count_next = '0;
            hold_count_next     = '0;
        end
        else
        begin
            case (phase_reg)
                PH_DEBOUNCE:
                begin
                    debounce_count_next = deb_inc;
                    if (CMP_W'(deb_inc) >= CMP_W'(debounce_ticks_reg))
                    begin
                        debounce_count_next = '0;
                        if (!level)
                        begin
                            phase_next      = PH_HOLD;
                            hold_count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_HOLD:
                begin
                    if (level)
                    begin
                        cls = (CMP_W'(hold_count_reg) < CMP_W'(short_limit_reg))
                              ? bplc_pkg::CLS_SHORT : bplc_pkg::CLS_MEDIUM;
                        phase_next      = PH_IDLE;
                        hold_count_next = '0;
                    end
                    else
                    begin
                        hold_count_next = hold_inc;
                        if (CMP_W'(hold_inc) >= CMP_W'(long_limit_reg))
                        begin
                            cls             = bplc_pkg::CLS_LONG;
                            phase_next      = PH_IDLE;
                            hold_count_next = '0;
                        end
                    end
                end
                default:
                begin
                    // Idle and the unused code both wait for a falling edge
                    phase_next = PH_IDLE;
                    if (prev_level_reg && !level)
                    begin
                        phase_next          = PH_DEBOUNCE;
                        debounce_count_next = '0;
                    end
                end
            endcase
        end
    end

    assign result.press_class = cls;
    assign result.idle_flag   = (phase_next == PH_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b0;
            debounce_ticks_reg <= bplc_pkg::DEBOUNCE_RESET;
            short_limit_reg    <= bplc_pkg::SHORT_LIMIT_RESET;
            long_limit_reg     <= bplc_pkg::LONG_LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            case (bplc_pkg::cfg_index_t'(cfg_index))
                bplc_pkg::REG_ENABLE:      enable_reg         <= cfg_wdata[0];
                bplc_pkg::REG_DEBOUNCE:    debounce_ticks_reg <= cfg_wdata;
                bplc_pkg::REG_SHORT_LIMIT: short_limit_reg    <= cfg_wdata;
                bplc_pkg::REG_LONG_LIMIT:  long_limit_reg     <= cfg_wdata;
                default:                   enable_reg         <= enable_reg;
            endcase
        end
    end

    // Advance phase and counters once per accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            prev_level_reg     <= 1'b1;
            debounce_count_reg <= '0;
            hold_count_reg     <= '0;
        end
        else if (beat)
        begin
            phase_reg          <= phase_next;
            prev_level_reg     <= level;
            debounce_count_reg <= debounce_count_next;
            hold_count_reg     <= hold_count_next;
        end
    end

    a_class_ends_press: assert property (@(posedge clk) disable iff (!rst_n)
        (result.press_class != bplc_pkg::CLS_NONE) |-> result.idle_flag)
        else $error("press reported while a phase stays pending");

    a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !enable_reg |-> (result.idle_flag && result.press_class == bplc_pkg::CLS_NONE))
        else $error("disabled block reports activity");

    a_long_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.press_class != bplc_pkg::CLS_NONE) |-> (phase_reg == PH_HOLD))
        else $error("press reported outside the hold phase");

    a_debounce_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && phase_reg == PH_IDLE) |=> (debounce_count_reg == '0))
        else $error("debounce count not cleared when leaving idle");

endmodule

>>> src/bplc_out_buf.sv
// Result register with a skid stage for the output stream.
module bplc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bplc_pkg::result_t push_data,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bplc_pkg::result_t out_data
);

    logic              out_valid_reg, skid_valid_reg;
    bplc_pkg::result_t out_data_reg, skid_data_reg;
    logic              pop;

    assign pop       = out_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
            if (push)
            begin
                skid_data_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output is empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !pop) |=> skid_valid_reg)
        else $error("waiting skid beat lost");

    a_skid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && out_data_reg == $past(skid_data_reg)))
        else $error("skid beat not moved to output");

endmodule

>>> src/button_press_length_classifier.sv
// Top level of the debounced button press length classifier.
//
// Usage: feed one button sample per millisecond tick on the s_axis stream
// (tdata bit 0 = pin level, 0 pressed). Every accepted beat produces exactly
// one result beat on m_axis: press class (none/short/medium/long) and an idle
// flag that tells software the block may sleep.
// Configuration (enable, debounce ticks, short and long limits) is written
// through cfg_wen/cfg_index/cfg_wdata while the stream is quiet; writes take
// effect at the next clock edge, with no read-back.
// Output: each result is held in the result register, or in the skid stage
// while that register waits, before it reaches m_axis. Throughput: one sample
// per cycle while s_axis_tready is high; the phase and counter update is a single
// compare-and-increment pass between the state registers and the result register.
// Stall: a result register plus a skid stage (two entries) keeps s_axis_tready
// high while one finished result waits; it drops only when both entries are
// full, and rises again in the cycle after m_axis_tready takes a beat.
// Reset (rst_n low, asynchronous): block disabled, phase idle, previous level
// released, counts cleared, limits back to 40/500/2000, result stream empty.
module button_press_length_classifier #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wen,
    input  logic [bplc_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
    input  logic [bplc_pkg::CFG_WIDTH-1:0]         cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [0] button_level, [7:1] zero
    input  logic [bplc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // [1:0] press_class, [2] idle_flag, [7:3] zero
    output logic [bplc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    logic              beat;
    bplc_pkg::result_t core_result;
    bplc_pkg::result_t out_result;

    // Accept a sample only when the result side has room for its beat
    assign beat = s_axis_tvalid && s_axis_tready;

    bplc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .beat      (beat),
        .level     (s_axis_tdata[0]),
        .result    (core_result)
    );

    bplc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (beat),
        .push_data (core_result),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    // Pack the result fields from the lowest bit up, zero fill to a byte
    assign m_axis_tdata = {{(bplc_pkg::OUT_TDATA_W-3){1'b0}},
                           out_result.idle_flag, out_result.press_class};

endmodule
